/* design/csp_pkg.sv */
// Shared types, constants and register codes for the cascaded speed/current controller.
package csp_pkg;

   // Fixed-point format of every gain and accumulator.
   localparam int GAIN_FRAC_BITS     = 16;
   localparam int CURRENT_TARGET_MAX = 100;

   // Field and state widths.
   localparam int MEAS_W      = 8;
   localparam int TARGET_W    = 7;
   localparam int DUTY_W      = 8;
   localparam int GAIN_W      = 24;
   localparam int ERR_W       = 9;
   localparam int SPEED_ACC_W = 40;
   localparam int CUR_ACC_W   = 32;
   localparam int CUR_STEP_W  = 36;
   localparam int CSR_IDX_W   = 3;

   // Duty limits of the current loop.
   localparam int DUTY_MAX  = 255;
   localparam int DUTY_PARK = 250;
   localparam int DUTY_MIN  = 1;

   // Speed accumulator bounds.
   localparam logic signed [SPEED_ACC_W-1:0] SPEED_ACC_ONE =
      SPEED_ACC_W'(1) << GAIN_FRAC_BITS;
   localparam logic signed [SPEED_ACC_W-1:0] SPEED_ACC_MAX =
      SPEED_ACC_W'(CURRENT_TARGET_MAX) << GAIN_FRAC_BITS;
   localparam logic signed [SPEED_ACC_W-1:0] SPEED_ACC_HIGH =
      SPEED_ACC_W'(CURRENT_TARGET_MAX + 1) << GAIN_FRAC_BITS;

   // Current accumulator and step bounds.
   localparam logic signed [CUR_ACC_W-1:0] CUR_ACC_ONE =
      CUR_ACC_W'(DUTY_MIN) << GAIN_FRAC_BITS;
   localparam logic signed [CUR_ACC_W-1:0] CUR_ACC_HIGH =
      CUR_ACC_W'(DUTY_MAX + 1) << GAIN_FRAC_BITS;
   localparam logic signed [CUR_ACC_W-1:0] CUR_ACC_PARK =
      CUR_ACC_W'(DUTY_PARK) << GAIN_FRAC_BITS;
   localparam logic signed [CUR_STEP_W-1:0] CUR_STEP_LIMIT =
      CUR_STEP_W'(DUTY_MAX) << GAIN_FRAC_BITS;

   // Run modes.
   localparam logic [1:0] MODE_AUTO   = 2'd0;
   localparam logic [1:0] MODE_MANUAL = 2'd1;
   localparam logic [1:0] MODE_FAIL   = 2'd2;

   // Opcodes.
   localparam logic OP_SPEED   = 1'b0;
   localparam logic OP_CURRENT = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_RUN_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_TARGET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_KP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_KI     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_KD     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CURRENT_KP   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CURRENT_KI   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MANUAL_DUTY  = 3'd7;

   typedef struct packed {
      logic              opcode;
      logic [MEAS_W-1:0] measured_value;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0]   duty_cycle;
      logic [TARGET_W-1:0] current_target;
   } rsp_type;

   typedef struct packed {
      logic [1:0]        run_mode;
      logic [MEAS_W-1:0] speed_target;
      logic [GAIN_W-1:0] speed_kp;
      logic [GAIN_W-1:0] speed_ki;
      logic [GAIN_W-1:0] speed_kd;
      logic [GAIN_W-1:0] current_kp;
      logic [GAIN_W-1:0] current_ki;
      logic [DUTY_W-1:0] manual_duty;
   } cfg_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]       err_prev;
      logic signed [ERR_W-1:0]       err_prev2;
      logic signed [SPEED_ACC_W-1:0] accum;
      logic [TARGET_W-1:0]           target;
   } spd_state_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]     err_prev;
      logic signed [CUR_ACC_W-1:0] accum;
      logic [DUTY_W-1:0]           duty;
   } cur_state_type;

endpackage

/* design/csp_cfg.sv */
// Configuration register file with write-only access.
module csp_cfg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [csp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [csp_pkg::GAIN_W-1:0]     csr_write_data,
   output csp_pkg::cfg_type               cfg
);

   csp_pkg::cfg_type cfg_ff;
   csp_pkg::cfg_type cfg_in;

   // Decode the index and replace one register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            csp_pkg::REG_RUN_MODE:     cfg_in.run_mode     = csr_write_data[1:0];
            csp_pkg::REG_SPEED_TARGET: cfg_in.speed_target = csr_write_data[7:0];
            csp_pkg::REG_SPEED_KP:     cfg_in.speed_kp     = csr_write_data;
            csp_pkg::REG_SPEED_KI:     cfg_in.speed_ki     = csr_write_data;
            csp_pkg::REG_SPEED_KD:     cfg_in.speed_kd     = csr_write_data;
            csp_pkg::REG_CURRENT_KP:   cfg_in.current_kp   = csr_write_data;
            csp_pkg::REG_CURRENT_KI:   cfg_in.current_ki   = csr_write_data;
            csp_pkg::REG_MANUAL_DUTY:  cfg_in.manual_duty  = csr_write_data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Registers come out of reset with the default tuning.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_mode     <= csp_pkg::MODE_MANUAL;
         cfg_ff.speed_target <= 8'd30;
         cfg_ff.speed_kp     <= 24'd89129;
         cfg_ff.speed_ki     <= 24'd89129;
         cfg_ff.speed_kd     <= 24'd58982;
         cfg_ff.current_kp   <= 24'd2359;
         cfg_ff.current_ki   <= 24'd10111;
         cfg_ff.manual_duty  <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/csp_speed.sv */
// Incremental PID step of the speed loop, producing the next current setpoint.
module csp_speed (
   input  csp_pkg::cfg_type                cfg,
   input  logic [csp_pkg::MEAS_W-1:0]      measured_value,
   input  csp_pkg::spd_state_type          state_cur,
   output csp_pkg::spd_state_type          state_next
);

   logic signed [csp_pkg::ERR_W-1:0]        err;
   logic signed [26:0]                      k1;
   logic signed [26:0]                      k2;
   logic signed [26:0]                      k3;
   logic signed [35:0]                      p1;
   logic signed [35:0]                      p2;
   logic signed [35:0]                      p3;
   logic signed [csp_pkg::SPEED_ACC_W-1:0]  acc_sum;

   // Error and the three combined gain terms.
   assign err = $signed({1'b0, cfg.speed_target}) - $signed({1'b0, measured_value});
   assign k1  = $signed({3'b000, cfg.speed_kp}) + $signed({3'b000, cfg.speed_ki})
              + $signed({3'b000, cfg.speed_kd});
   assign k2  = -($signed({3'b000, cfg.speed_kp}) + ($signed({3'b000, cfg.speed_kd}) <<< 1));
   assign k3  = $signed({3'b000, cfg.speed_kd});

   // Three parallel products, then one sum into the accumulator.
   assign p1 = k1 * err;
   assign p2 = k2 * state_cur.err_prev;
   assign p3 = k3 * state_cur.err_prev2;
   assign acc_sum = state_cur.accum + csp_pkg::SPEED_ACC_W'(p1)
                  + csp_pkg::SPEED_ACC_W'(p2) + csp_pkg::SPEED_ACC_W'(p3);

   // Clamp the integer part to the setpoint range; a small negative value truncates to zero.
   always_comb begin
      state_next.err_prev  = err;
      state_next.err_prev2 = state_cur.err_prev;
      if (acc_sum >= csp_pkg::SPEED_ACC_HIGH) begin
         state_next.accum  = csp_pkg::SPEED_ACC_MAX;
         state_next.target = csp_pkg::TARGET_W'(csp_pkg::CURRENT_TARGET_MAX);
      end else if (acc_sum <= -csp_pkg::SPEED_ACC_ONE) begin
         state_next.accum  = '0;
         state_next.target = '0;
      end else if (acc_sum < 0) begin
         state_next.accum  = acc_sum;
         state_next.target = '0;
      end else begin
         state_next.accum  = acc_sum;
         state_next.target = csp_pkg::TARGET_W'(acc_sum >>> csp_pkg::GAIN_FRAC_BITS);
      end
   end

endmodule

/* design/csp_current.sv */
// Incremental PI step of the current loop, producing the next duty cycle.
module csp_current (
   input  csp_pkg::cfg_type                cfg,
   input  logic [csp_pkg::MEAS_W-1:0]      measured_value,
   input  logic [csp_pkg::TARGET_W-1:0]    current_target,
   input  csp_pkg::cur_state_type          state_cur,
   output csp_pkg::cur_state_type          state_next
);

   logic signed [csp_pkg::ERR_W-1:0]       err;
   logic signed [25:0]                     k1;
   logic signed [25:0]                     k2;
   logic signed [34:0]                     p1;
   logic signed [34:0]                     p2;
   logic signed [csp_pkg::CUR_STEP_W-1:0]  step_raw;
   logic signed [csp_pkg::CUR_STEP_W-1:0]  step_lim;
   logic signed [csp_pkg::CUR_ACC_W-1:0]   acc_sum;

   // Error against the setpoint and the PI gain terms.
   assign err = $signed({2'b00, current_target}) - $signed({1'b0, measured_value});
   assign k1  = $signed({2'b00, cfg.current_kp}) + $signed({2'b00, cfg.current_ki});
   assign k2  = -$signed({2'b00, cfg.current_kp});

   assign p1       = k1 * err;
   assign p2       = k2 * state_cur.err_prev;
   assign step_raw = csp_pkg::CUR_STEP_W'(p1) + csp_pkg::CUR_STEP_W'(p2);

   // Limit the step to plus or minus full scale before it is accumulated.
   always_comb begin
      if (step_raw > csp_pkg::CUR_STEP_LIMIT) begin
         step_lim = csp_pkg::CUR_STEP_LIMIT;
      end else if (step_raw < -csp_pkg::CUR_STEP_LIMIT) begin
         step_lim = -csp_pkg::CUR_STEP_LIMIT;
      end else begin
         step_lim = step_raw;
      end
   end

   assign acc_sum = state_cur.accum + csp_pkg::CUR_ACC_W'(step_lim);

   // Overrange parks the duty, underrange holds it at the minimum.
   always_comb begin
      state_next.err_prev = err;
      if (acc_sum >= csp_pkg::CUR_ACC_HIGH) begin
         state_next.accum = csp_pkg::CUR_ACC_PARK;
         state_next.duty  = csp_pkg::DUTY_W'(csp_pkg::DUTY_PARK);
      end else if (acc_sum < csp_pkg::CUR_ACC_ONE) begin
         state_next.accum = csp_pkg::CUR_ACC_ONE;
         state_next.duty  = csp_pkg::DUTY_W'(csp_pkg::DUTY_MIN);
      end else begin
         state_next.accum = acc_sum;
         state_next.duty  = csp_pkg::DUTY_W'(acc_sum >>> csp_pkg::GAIN_FRAC_BITS);
      end
   end

endmodule

/* design/cascaded_speed_current_pid.sv */
// Cascaded speed PID and current PI controller: input stage, loop state and result stage.
//
// Each request word carries an opcode and a measured byte. A speed word runs the
// speed loop and updates the current setpoint; a current word runs the current
// loop and updates the duty cycle. Manual mode drives the manual duty, fail mode
// drives zero duty and clears the previous errors. Every request word yields
// exactly one response word holding the duty and the setpoint after the update.
// A request is captured in an input register; the whole loop update (three parallel
// multiplies for speed, two for current, adds and clamps) runs as the word moves on
// and lands in the response register. One word is taken every cycle while the receiver
// does not stall. When the receiver stalls, the response register holds its word and
// the input register holds the next one; the request side stalls only when both are
// full. The configuration port is a plain write port; the user must write it only
// while no word is in flight, which the block does not enforce. Reset is synchronous:
// it empties both stages, clears all loop state and restores the default tuning.
module cascaded_speed_current_pid (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  csp_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output csp_pkg::rsp_type               rsp_data,
   input  logic                           csr_write_enable,
   input  logic [csp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [csp_pkg::GAIN_W-1:0]     csr_write_data
);

   csp_pkg::cfg_type        cfg;
   logic                    in_valid_ff;
   csp_pkg::req_type        in_data_ff;
   logic                    rsp_valid_ff;
   csp_pkg::rsp_type        rsp_data_ff;
   csp_pkg::rsp_type        rsp_data_in;
   csp_pkg::spd_state_type  spd_ff;
   csp_pkg::spd_state_type  spd_in;
   csp_pkg::spd_state_type  spd_step;
   csp_pkg::cur_state_type  cur_ff;
   csp_pkg::cur_state_type  cur_in;
   csp_pkg::cur_state_type  cur_step;
   logic                    advance;

   csp_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   csp_speed u_speed (
      .cfg            (cfg),
      .measured_value (in_data_ff.measured_value),
      .state_cur      (spd_ff),
      .state_next     (spd_step)
   );

   csp_current u_current (
      .cfg            (cfg),
      .measured_value (in_data_ff.measured_value),
      .current_target (spd_ff.target),
      .state_cur      (cur_ff),
      .state_next     (cur_step)
   );

   // The held word moves on when the response register is free or being emptied.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Select the state update by run mode and opcode.
   always_comb begin
      spd_in = spd_ff;
      cur_in = cur_ff;
      case (cfg.run_mode)
         csp_pkg::MODE_AUTO: begin
            if (in_data_ff.opcode == csp_pkg::OP_SPEED) begin
               spd_in = spd_step;
            end else begin
               cur_in = cur_step;
            end
         end
         csp_pkg::MODE_MANUAL: begin
            cur_in.duty = cfg.manual_duty;
         end
         csp_pkg::MODE_FAIL: begin
            cur_in.duty     = '0;
            cur_in.err_prev = '0;
            spd_in.err_prev = '0;
         end
         default: begin
            spd_in = spd_ff;
            cur_in = cur_ff;
         end
      endcase
      rsp_data_in.duty_cycle     = cur_in.duty;
      rsp_data_in.current_target = spd_in.target;
   end

   // Input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Loop state is updated once per word, as the word moves to the response stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         spd_ff <= '0;
         cur_ff <= '0;
      end else if (advance) begin
         spd_ff <= spd_in;
         cur_ff <= cur_in;
      end
   end

   // Response stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // The setpoint never leaves its clamp range.
   a_target_range: assert property (@(posedge clock) disable iff (reset)
      spd_ff.target <= csp_pkg::TARGET_W'(csp_pkg::CURRENT_TARGET_MAX))
      else $error("current setpoint above its maximum");

   // The current accumulator stays non-negative and below the overrange bound.
   a_cur_acc_range: assert property (@(posedge clock) disable iff (reset)
      (cur_ff.accum >= 0) && (cur_ff.accum < csp_pkg::CUR_ACC_HIGH))
      else $error("current accumulator out of range");

   // A word that moves on always shows up as a valid response next cycle.
   a_advance_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced word did not reach the response stage");

   // A fail-mode word drives zero duty and clears the previous errors.
   a_fail_stop: assert property (@(posedge clock) disable iff (reset)
      (advance && cfg.run_mode == csp_pkg::MODE_FAIL) |=>
      (rsp_data_ff.duty_cycle == '0) && (spd_ff.err_prev == '0) && (cur_ff.err_prev == '0))
      else $error("fail mode did not stop the drive");

   // A held input word is not lost while the response side stalls.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled input word dropped");
`endif

endmodule
